/* rtl/chroma_subsample_444_to_422_420_macros.svh */
// Assertion macros used by the chroma subsampler averaging module (css_avg).
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef CHROMA_SUBSAMPLE_444_TO_422_420_MACROS_SVH
`define CHROMA_SUBSAMPLE_444_TO_422_420_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chroma subsampler check failed");

// Next-cycle implication, checked outside reset.
`define CSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chroma subsampler check failed");

`endif

/* rtl/css_pkg.sv */
package css_pkg;

    localparam int PIX_W  = 30;
    localparam int COMP_W = 10;
    localparam int POS_W  = 13;
    localparam int LINE_W = 2 * COMP_W;

    // Bit positions of the components inside the packed pixel.
    localparam int LUMA_LSB = 20;
    localparam int CB_LSB   = 10;
    localparam logic [COMP_W-1:0] COMP_MASK = 10'h3ff;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ENABLE  = 2'd0;
    localparam t_cfg_idx CFG_PATTERN = 2'd1;
    localparam t_cfg_idx CFG_WIDTH   = 2'd2;
    localparam t_cfg_idx CFG_HEIGHT  = 2'd3;

    localparam logic [POS_W-1:0] WIDTH_RST  = 13'd1920;
    localparam logic [POS_W-1:0] HEIGHT_RST = 13'd1080;

    // One pixel on its way from the position stage to the averaging stage.
    typedef struct packed {
        logic              enable;
        logic              pattern;
        logic              odd_col;
        logic              odd_row;
        logic              rd_ok;
        logic [COMP_W-1:0] luma;
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
    } t_stage;

endpackage

/* rtl/chroma_subsample_444_to_422_420.sv */
// Chroma subsampler from packed 4:4:4 pixels to 4:2:2 or 4:2:0, one pixel per
// clock while the output is not stalled, through stage and output registers;
// every pixel gives exactly one result, and luma always passes. The pixel
// position is tracked from the configured frame size. In 4:2:0 mode the chroma
// of even rows is kept in a single-port-write, single-port-read line buffer of MAX_LINE
// entries with registered read data, and the odd row reads it back in its own pipeline
// slot. Configuration is taken at any time but must only be changed while no pixel is
// in flight. The line buffer is not cleared after reset; the user, not the block, must
// ensure that an odd row only reads entries that the even row above it wrote.
module chroma_subsample_444_to_422_420 #(
    parameter int MAX_LINE = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  css_pkg::t_cfg_idx           i_cfg_index,
    input  logic [css_pkg::POS_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [css_pkg::PIX_W-1:0]   i_pixel,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [css_pkg::COMP_W-1:0]  o_luma_out,
    output logic [css_pkg::COMP_W-1:0]  o_cb_out,
    output logic [css_pkg::COMP_W-1:0]  o_cr_out,
    output logic                        o_chroma_valid
);
    import css_pkg::*;

    localparam int AW = $clog2(MAX_LINE);

    logic              w_accept;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [AW-1:0]     w_addr;
    logic [LINE_W-1:0] w_wr_data;
    logic [LINE_W-1:0] w_rd_data;
    t_stage            w_stage;

    assign o_cfg_ready = 1'b1;

    css_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_pixel     (i_pixel),
        .o_wr_en     (w_wr_en),
        .o_rd_en     (w_rd_en),
        .o_addr      (w_addr),
        .o_wr_data   (w_wr_data),
        .o_stage     (w_stage)
    );

    css_line_buf #(
        .DEPTH (MAX_LINE)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    css_avg u_avg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_stage        (w_stage),
        .i_rd_data      (w_rd_data),
        .i_out_stall    (i_out_stall),
        .o_accept       (w_accept),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_luma_out     (o_luma_out),
        .o_cb_out       (o_cb_out),
        .o_cr_out       (o_cr_out),
        .o_chroma_valid (o_chroma_valid)
    );

endmodule

/* rtl/css_line_buf.sv */
module css_line_buf #(
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [css_pkg::LINE_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [css_pkg::LINE_W-1:0] o_rd_data
);
    import css_pkg::*;

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/css_front.sv */
module css_front #(
    parameter int MAX_LINE = 8192,
    localparam int AW = $clog2(MAX_LINE)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr,
    input  css_pkg::t_cfg_idx         i_cfg_index,
    input  logic [css_pkg::POS_W-1:0] i_cfg_data,
    input  logic                      i_accept,
    input  logic [css_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_wr_en,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_addr,
    output logic [css_pkg::LINE_W-1:0] o_wr_data,
    output css_pkg::t_stage           o_stage
);
    import css_pkg::*;

    logic             r_enable;
    logic             r_pattern;
    logic [POS_W-1:0] r_width;
    logic [POS_W-1:0] r_height;
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;

    logic [POS_W-1:0] w_last_col;
    logic [POS_W-1:0] w_last_row;
    logic             w_in_range;
    logic             w_line_mode;
    logic [POS_W-1:0] n_col;
    logic [POS_W-1:0] n_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_pattern <= 1'b0;
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_ENABLE:  r_enable  <= i_cfg_data[0];
                CFG_PATTERN: r_pattern <= i_cfg_data[0];
                CFG_WIDTH:   r_width   <= i_cfg_data;
                CFG_HEIGHT:  r_height  <= i_cfg_data;
                default:     r_enable  <= r_enable;
            endcase
        end
    end

    // A size of zero behaves as a size of one, so its last position is zero.
    assign w_last_col = (r_width == '0) ? '0 : r_width - POS_W'(1);
    assign w_last_row = (r_height == '0) ? '0 : r_height - POS_W'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (r_col >= w_last_col) begin
            n_col = '0;
            n_row = (r_row >= w_last_row) ? '0 : r_row + POS_W'(1);
        end else begin
            n_col = r_col + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign w_in_range  = {1'b0, r_col} < (POS_W + 1)'(MAX_LINE);
    assign w_line_mode = r_enable & r_pattern;

    // Even rows of 4:2:0 fill the line buffer, odd rows read it back.
    assign o_wr_en   = i_accept & w_line_mode & ~r_row[0] & w_in_range;
    assign o_rd_en   = i_accept & w_line_mode & r_row[0];
    assign o_addr    = r_col[AW-1:0];
    assign o_wr_data = i_pixel[LINE_W-1:0];

    always_comb begin
        o_stage.enable  = r_enable;
        o_stage.pattern = r_pattern;
        o_stage.odd_col = r_col[0];
        o_stage.odd_row = r_row[0];
        o_stage.rd_ok   = w_in_range;
        o_stage.luma    = i_pixel[LUMA_LSB +: COMP_W] & COMP_MASK;
        o_stage.cb      = i_pixel[CB_LSB +: COMP_W] & COMP_MASK;
        o_stage.cr      = i_pixel[0 +: COMP_W] & COMP_MASK;
    end

endmodule

/* rtl/css_avg.sv */
module css_avg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  css_pkg::t_stage             i_stage,
    input  logic [css_pkg::LINE_W-1:0]  i_rd_data,
    input  logic                        i_out_stall,
    output logic                        o_accept,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output logic [css_pkg::COMP_W-1:0]  o_luma_out,
    output logic [css_pkg::COMP_W-1:0]  o_cb_out,
    output logic [css_pkg::COMP_W-1:0]  o_cr_out,
    output logic                        o_chroma_valid
);
    import css_pkg::*;
    `include "chroma_subsample_444_to_422_420_macros.svh"

    logic              r_s1_valid;
    t_stage            r_s1;
    logic              r_out_valid;
    logic [COMP_W-1:0] r_luma;
    logic [COMP_W-1:0] r_cb;
    logic [COMP_W-1:0] r_cr;
    logic              r_cvalid;
    logic [COMP_W:0]   r_pair_cb;
    logic [COMP_W:0]   r_pair_cr;
    logic [COMP_W+1:0] r_blk_cb;
    logic [COMP_W+1:0] r_blk_cr;

    logic              w_s1_adv;
    logic [COMP_W-1:0] w_lcb;
    logic [COMP_W-1:0] w_lcr;
    logic [COMP_W:0]   w_pair_cb;
    logic [COMP_W:0]   w_pair_cr;
    logic [COMP_W+1:0] w_blk_cb;
    logic [COMP_W+1:0] w_blk_cr;
    logic [COMP_W:0]   n_pair_cb;
    logic [COMP_W:0]   n_pair_cr;
    logic [COMP_W+1:0] n_blk_cb;
    logic [COMP_W+1:0] n_blk_cr;
    logic [COMP_W-1:0] n_cb;
    logic [COMP_W-1:0] n_cr;
    logic              n_cvalid;

    // The stage moves on whenever the output register is free or being drained.
    assign w_s1_adv   = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~w_s1_adv;
    assign o_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_s1 <= i_stage;
        end
    end

    // The line buffer data lines up with the stage register; columns past
    // the buffer read as zero.
    assign w_lcb = r_s1.rd_ok ? i_rd_data[CB_LSB +: COMP_W] : '0;
    assign w_lcr = r_s1.rd_ok ? i_rd_data[0 +: COMP_W] : '0;

    assign w_pair_cb = r_pair_cb + {1'b0, r_s1.cb};
    assign w_pair_cr = r_pair_cr + {1'b0, r_s1.cr};
    assign w_blk_cb  = (r_s1.odd_col ? r_blk_cb : '0) + {2'b00, r_s1.cb} + {2'b00, w_lcb};
    assign w_blk_cr  = (r_s1.odd_col ? r_blk_cr : '0) + {2'b00, r_s1.cr} + {2'b00, w_lcr};

    always_comb begin
        n_pair_cb = r_pair_cb;
        n_pair_cr = r_pair_cr;
        n_blk_cb  = r_blk_cb;
        n_blk_cr  = r_blk_cr;
        n_cb      = '0;
        n_cr      = '0;
        n_cvalid  = 1'b0;
        if (!r_s1.enable) begin
            n_cb     = r_s1.cb;
            n_cr     = r_s1.cr;
            n_cvalid = 1'b1;
        end else if (!r_s1.pattern) begin
            if (!r_s1.odd_col) begin
                n_pair_cb = {1'b0, r_s1.cb};
                n_pair_cr = {1'b0, r_s1.cr};
            end else begin
                n_pair_cb = w_pair_cb;
                n_pair_cr = w_pair_cr;
                n_cb      = w_pair_cb[COMP_W:1];
                n_cr      = w_pair_cr[COMP_W:1];
                n_cvalid  = 1'b1;
            end
        end else if (r_s1.odd_row) begin
            n_blk_cb = w_blk_cb;
            n_blk_cr = w_blk_cr;
            if (r_s1.odd_col) begin
                n_cb     = w_blk_cb[COMP_W+1:2];
                n_cr     = w_blk_cr[COMP_W+1:2];
                n_cvalid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_cb <= '0;
            r_pair_cr <= '0;
            r_blk_cb  <= '0;
            r_blk_cr  <= '0;
        end else if (w_s1_adv) begin
            r_pair_cb <= n_pair_cb;
            r_pair_cr <= n_pair_cr;
            r_blk_cb  <= n_blk_cb;
            r_blk_cr  <= n_blk_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_luma   <= r_s1.luma;
            r_cb     <= n_cb;
            r_cr     <= n_cr;
            r_cvalid <= n_cvalid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_luma_out     = r_luma;
    assign o_cb_out       = r_cb;
    assign o_cr_out       = r_cr;
    assign o_chroma_valid = r_cvalid;

    `CSS_ASSERT_SAME(a_no_chroma_is_zero, o_out_valid && !o_chroma_valid, o_cb_out == '0 && o_cr_out == '0)
    `CSS_ASSERT_NEXT(a_blocked_item_kept, r_s1_valid && r_out_valid && i_out_stall, r_s1_valid)
    `CSS_ASSERT_NEXT(a_advance_fills_out, w_s1_adv, r_out_valid)

endmodule

/* test/tb_chroma_subsample_444_to_422_420.sv */
`timescale 1ns / 100ps

module tb_chroma_subsample_444_to_422_420;
    import css_pkg::*;

    localparam int LINE_DEPTH = 8192;

    typedef struct packed {
        logic [COMP_W-1:0] luma;
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
        logic              cv;
    } t_chroma_res;

    typedef struct packed {
        logic             is_cfg;
        t_cfg_idx         reg_idx;
        logic [POS_W-1:0] reg_val;
        logic [PIX_W-1:0] pix;
        logic             typed;
        t_chroma_res      res;
    } t_dir_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    t_cfg_idx          cfg_index = CFG_ENABLE;
    logic [POS_W-1:0]  cfg_data = '0;
    logic              pix_valid = 1'b0;
    logic [PIX_W-1:0]  pix_data = '0;
    logic              out_stall = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [COMP_W-1:0] o_luma_out;
    logic [COMP_W-1:0] o_cb_out;
    logic [COMP_W-1:0] o_cr_out;
    logic              o_chroma_valid;

    // Predictor copy of the configuration and of the block state.
    logic              cfg_enable = 1'b0;
    logic              cfg_pattern = 1'b0;
    logic [POS_W-1:0]  cfg_width = WIDTH_RST;
    logic [POS_W-1:0]  cfg_height = HEIGHT_RST;
    logic [POS_W-1:0]  pos_col = '0;
    logic [POS_W-1:0]  pos_row = '0;
    logic [10:0]       pair_cb = '0;
    logic [10:0]       pair_cr = '0;
    logic [11:0]       blk_cb = '0;
    logic [11:0]       blk_cr = '0;
    bit   [19:0]       even_row_chroma [LINE_DEPTH];
    bit                even_row_written [LINE_DEPTH];

    t_chroma_res       pending_results [$];
    t_dir_row          dir_rows [$];
    int                mismatches = 0;
    int                pixels_sent = 0;
    int                burst_left = 0;
    int                stall_mode = 0;
    int                stall_span = 0;
    int unsigned       rx_tick = 0;

    chroma_subsample_444_to_422_420 dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (pix_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (pix_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_luma_out     (o_luma_out),
        .o_cb_out       (o_cb_out),
        .o_cr_out       (o_cr_out),
        .o_chroma_valid (o_chroma_valid)
    );

    always #1 clk = ~clk;

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // A size of zero acts as one; the position wraps once it reaches the last slot.
    function automatic void advance_pos(inout logic [POS_W-1:0] c, inout logic [POS_W-1:0] r,
                                        input logic [POS_W-1:0] wd, input logic [POS_W-1:0] ht);
        logic [POS_W-1:0] w;
        logic [POS_W-1:0] h;
        w = (wd == 0) ? 13'd1 : wd;
        h = (ht == 0) ? 13'd1 : ht;
        if (c >= w - 13'd1) begin
            c = '0;
            if (r >= h - 13'd1) begin
                r = '0;
            end else begin
                r = r + 13'd1;
            end
        end else begin
            c = c + 13'd1;
        end
    endfunction

    function automatic t_chroma_res predict_subsample(logic [PIX_W-1:0] pix);
        t_chroma_res       res;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
        logic [COMP_W-1:0] lcb;
        logic [COMP_W-1:0] lcr;
        y  = pix[LUMA_LSB +: COMP_W];
        cb = pix[CB_LSB +: COMP_W];
        cr = pix[0 +: COMP_W];
        res = '0;
        res.luma = y;
        if (!cfg_enable) begin
            res.cb = cb;
            res.cr = cr;
            res.cv = 1'b1;
        end else if (!cfg_pattern) begin
            if (!pos_col[0]) begin
                pair_cb = {1'b0, cb};
                pair_cr = {1'b0, cr};
            end else begin
                pair_cb = pair_cb + {1'b0, cb};
                pair_cr = pair_cr + {1'b0, cr};
                res.cb = pair_cb[10:1];
                res.cr = pair_cr[10:1];
                res.cv = 1'b1;
            end
        end else if (!pos_row[0]) begin
            even_row_chroma[pos_col] = {cb, cr};
            even_row_written[pos_col] = 1'b1;
        end else begin
            lcb = even_row_chroma[pos_col][19:10];
            lcr = even_row_chroma[pos_col][9:0];
            if (!pos_col[0]) begin
                blk_cb = {2'b0, cb} + {2'b0, lcb};
                blk_cr = {2'b0, cr} + {2'b0, lcr};
            end else begin
                blk_cb = blk_cb + {2'b0, cb} + {2'b0, lcb};
                blk_cr = blk_cr + {2'b0, cr} + {2'b0, lcr};
                res.cb = blk_cb[11:2];
                res.cr = blk_cr[11:2];
                res.cv = 1'b1;
            end
        end
        advance_pos(pos_col, pos_row, cfg_width, cfg_height);
        return res;
    endfunction

    // Walks the next n positions under a candidate setting and tells whether every
    // odd-row read in 4:2:0 mode finds an entry that an even row has written.
    function automatic bit line_reads_ok(logic en, logic pat, logic [POS_W-1:0] wd,
                                         logic [POS_W-1:0] ht, int n);
        bit               seen [LINE_DEPTH];
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] r;
        if (!(en && pat)) return 1'b1;
        seen = even_row_written;
        c = pos_col;
        r = pos_row;
        for (int k = 0; k < n; k++) begin
            if (!r[0]) begin
                seen[c] = 1'b1;
            end else if (!seen[c]) begin
                return 1'b0;
            end
            advance_pos(c, r, wd, ht);
        end
        return 1'b1;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0: p[k*COMP_W +: COMP_W] = '0;
                1: p[k*COMP_W +: COMP_W] = COMP_MASK;
                default: p[k*COMP_W +: COMP_W] = COMP_W'($urandom_range(0, 1023));
            endcase
        end
        return p;
    endfunction

    function automatic t_dir_row cfg_row(t_cfg_idx idx, logic [POS_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row pix_row(logic [PIX_W-1:0] pix);
        t_dir_row r;
        r = '0;
        r.pix = pix;
        return r;
    endfunction

    function automatic t_dir_row chk_row(logic [PIX_W-1:0] pix, logic [COMP_W-1:0] y,
                                         logic [COMP_W-1:0] cb, logic [COMP_W-1:0] cr,
                                         logic cv);
        t_dir_row r;
        r = '0;
        r.pix = pix;
        r.typed = 1'b1;
        r.res = '{luma: y, cb: cb, cr: cr, cv: cv};
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [POS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_ENABLE:  cfg_enable  = val[0];
            CFG_PATTERN: cfg_pattern = val[0];
            CFG_WIDTH:   cfg_width   = val;
            CFG_HEIGHT:  cfg_height  = val;
            default: ;
        endcase
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] pix, logic typed, t_chroma_res typed_res);
        t_chroma_res pred;
        int          gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pix_valid <= 1'b1;
        pix_data  <= pix;
        do @(posedge clk); while (o_in_stall);
        burst_left--;
        pixels_sent++;
        pred = predict_subsample(pix);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Settings change only with nothing in flight.
    task automatic drain_pipeline();
        pix_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(8, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (rx_tick % 3 == 0);
        endcase
    end

    always @(posedge clk) begin
        t_chroma_res want;
        t_chroma_res got;
        if (rst_n && o_out_valid && !out_stall) begin
            got = '{luma: o_luma_out, cb: o_cb_out, cr: o_cr_out, cv: o_chroma_valid};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer: luma %h cb %h cr %h chroma_valid %b",
                         $time, got.luma, got.cb, got.cr, got.cv);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: expected luma %h cb %h cr %h chroma_valid %b", $time,
                             want.luma, want.cb, want.cr, want.cv);
                    $display("%0t: actual   luma %h cb %h cr %h chroma_valid %b", $time,
                             got.luma, got.cb, got.cr, got.cv);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic             prev_cfg;
        logic             new_en;
        logic             new_pat;
        logic [POS_W-1:0] new_w;
        logic [POS_W-1:0] new_h;
        logic [3:0]       wr_mask;
        int               run_len;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            // Pass-through right after reset.
            chk_row(30'h0000_0000, 10'h000, 10'h000, 10'h000, 1'b1),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h3ff, 10'h3ff, 1'b1),
            chk_row(30'h2AAA_AAAA, 10'h2aa, 10'h2aa, 10'h2aa, 1'b1),
            chk_row(30'h1555_5555, 10'h155, 10'h155, 10'h155, 1'b1),
            // 4:2:2 with the column already past the new, narrower frame.
            cfg_row(CFG_WIDTH, 13'd4),
            cfg_row(CFG_HEIGHT, 13'd2),
            cfg_row(CFG_PATTERN, 13'd0),
            cfg_row(CFG_ENABLE, 13'd1),
            pix_row(30'h1234_5678),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h000, 10'h000, 1'b0),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h3ff, 10'h3ff, 1'b1),
            chk_row(30'h0000_0000, 10'h000, 10'h000, 10'h000, 1'b0),
            chk_row(30'h0000_0001, 10'h000, 10'h000, 10'h000, 1'b1),
            // 4:2:0 over two frames of 2x2.
            cfg_row(CFG_PATTERN, 13'd1),
            cfg_row(CFG_WIDTH, 13'd2),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h000, 10'h000, 1'b0),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h000, 10'h000, 1'b0),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h000, 10'h000, 1'b0),
            chk_row(30'h3FFF_FFFF, 10'h3ff, 10'h3ff, 10'h3ff, 1'b1),
            pix_row(30'h0000_0402),
            pix_row(30'h0000_0000),
            pix_row(30'h0000_0000),
            pix_row(30'h0000_0001),
            // A zero frame size behaves as one pixel, so every column is even.
            cfg_row(CFG_PATTERN, 13'd0),
            cfg_row(CFG_WIDTH, 13'd0),
            cfg_row(CFG_HEIGHT, 13'd0),
            chk_row(30'h3FF0_0C01, 10'h3ff, 10'h000, 10'h000, 1'b0),
            chk_row(30'h000F_FFFF, 10'h000, 10'h000, 10'h000, 1'b0),
            cfg_row(CFG_ENABLE, 13'd0),
            cfg_row(CFG_WIDTH, 13'd8191),
            cfg_row(CFG_HEIGHT, 13'd8191),
            chk_row(30'h2AAA_AAAA, 10'h2aa, 10'h2aa, 10'h2aa, 1'b1),
            chk_row(30'h1555_5555, 10'h155, 10'h155, 10'h155, 1'b1)
        };

        prev_cfg = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                if (!prev_cfg) drain_pipeline();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                if (prev_cfg) cfg_valid <= 1'b0;
                send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);
            end
            prev_cfg = dir_rows[i].is_cfg;
        end

        while (pixels_sent < 870) begin
            new_en  = cfg_enable;
            new_pat = cfg_pattern;
            new_w   = cfg_width;
            new_h   = cfg_height;
            wr_mask = 4'($urandom_range(1, 15));
            if (wr_mask[0]) new_en = ($urandom_range(0, 4) != 0);
            if (wr_mask[1]) new_pat = 1'($urandom_range(0, 1));
            if (wr_mask[2]) begin
                case ($urandom_range(0, 11))
                    0: new_w = '0;
                    1: new_w = 13'd8191;
                    2, 3: new_w = 13'($urandom_range(17, 80));
                    default: new_w = 13'($urandom_range(1, 16));
                endcase
            end
            if (wr_mask[3]) begin
                case ($urandom_range(0, 9))
                    0: new_h = '0;
                    1: new_h = 13'd8191;
                    default: new_h = 13'($urandom_range(1, 6));
                endcase
            end
            run_len = $urandom_range(10, 60);
            drain_pipeline();

            // A 1x1 frame brings the position back to the top left in one transfer,
            // so the next 4:2:0 run starts on an even row.
            if (!line_reads_ok(new_en, new_pat, new_w, new_h, run_len)) begin
                write_reg(CFG_ENABLE, 13'd0);
                write_reg(CFG_WIDTH, 13'd1);
                write_reg(CFG_HEIGHT, 13'd1);
                cfg_valid <= 1'b0;
                send_pixel(rand_pixel(), 1'b0, '0);
                drain_pipeline();
                wr_mask = 4'hf;
            end

            if (wr_mask[0]) write_reg(CFG_ENABLE, 13'(new_en));
            if (wr_mask[1]) write_reg(CFG_PATTERN, 13'(new_pat));
            if (wr_mask[2]) write_reg(CFG_WIDTH, new_w);
            if (wr_mask[3]) write_reg(CFG_HEIGHT, new_h);
            cfg_valid <= 1'b0;
            repeat (run_len) send_pixel(rand_pixel(), 1'b0, '0);
        end

        drain_pipeline();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/css_pkg.sv
rtl/css_line_buf.sv
rtl/css_front.sv
rtl/css_avg.sv
rtl/chroma_subsample_444_to_422_420.sv
test/tb_chroma_subsample_444_to_422_420.sv
